FILE: design/aas_pkg.sv
// Shared types, constants and saturation helper for the axisymmetric adjoint source block.
`default_nettype none
package aas_pkg;

    localparam int unsigned NUM_VARS    = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned HEAT_W      = 18;
    localparam int unsigned VOL_W       = 31;
    localparam logic [HEAT_W-1:0] HEAT_RESET = 18'd91750;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    typedef struct packed {
        logic signed [31:0]               radius;
        logic [VOL_W-1:0]                 cell_volume;
        logic signed [31:0]               density;
        logic signed [31:0]               momentum_axial;
        logic signed [31:0]               momentum_radial;
        logic signed [31:0]               total_energy;
        logic [NUM_VARS-1:0][31:0]        adjoint;
        logic                             bad;
        logic                             skip;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DWAIT,
        ST_MUL,
        ST_RES,
        ST_EMIT
    } t_back_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/aas_div.sv
// Restoring divider, one quotient bit per cycle, giving sat(floor(num * 2^16 / den)).
`default_nettype none
module aas_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic [31:0]        i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quo
);
    import aas_pkg::*;

    localparam int unsigned QW = 48;

    logic              r_busy;
    logic              r_fin;
    logic [5:0]        r_cnt;
    logic [31:0]       r_rem;
    logic [QW-1:0]     r_dvd;
    logic [QW-1:0]     r_quo;
    logic [31:0]       r_den;
    logic              r_neg;
    logic [31:0]       mag;
    logic [32:0]       trial;
    logic              qbit;
    logic signed [49:0] sq;

    assign mag   = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign trial = {r_rem, r_dvd[QW-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {mag, 16'd0};
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            r_rem <= qbit ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], qbit};
        end
    end

    // A negative dividend rounds toward minus infinity when the remainder is nonzero.
    always_comb begin
        if (r_neg) begin
            sq = 50'sd0 - $signed({2'b00, r_quo}) - $signed({49'd0, |r_rem});
        end else begin
            sq = $signed({2'b00, r_quo});
        end
    end

    assign o_quo  = sat32(64'(sq));
    assign o_done = r_fin;

endmodule
`default_nettype wire

FILE: design/aas_front.sv
// Front end: takes input words, flags zeroed cases and holds them in a short queue.
`default_nettype none
module aas_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [31:0]           i_radius,
    input  wire logic [aas_pkg::VOL_W-1:0]    i_cell_volume,
    input  wire logic signed [31:0]           i_density,
    input  wire logic signed [31:0]           i_momentum_axial,
    input  wire logic signed [31:0]           i_momentum_radial,
    input  wire logic signed [31:0]           i_total_energy,
    input  wire logic signed [31:0]           i_adjoint_0,
    input  wire logic signed [31:0]           i_adjoint_1,
    input  wire logic signed [31:0]           i_adjoint_2,
    input  wire logic signed [31:0]           i_adjoint_3,
    output logic                              o_q_valid,
    output aas_pkg::t_item                    o_q_item,
    input  wire logic                         i_q_pop
);
    import aas_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    t_item         item;
    logic          push;
    logic          pop;

    always_comb begin
        item.radius          = i_radius;
        item.cell_volume     = i_cell_volume;
        item.density         = i_density;
        item.momentum_axial  = i_momentum_axial;
        item.momentum_radial = i_momentum_radial;
        item.total_energy    = i_total_energy;
        item.adjoint         = {i_adjoint_3, i_adjoint_2, i_adjoint_1, i_adjoint_0};
        item.bad             = (i_density <= 32'sd0);
        // A nonpositive radius gives a zero scale, so the whole row set is zero.
        item.skip            = (i_radius <= 32'sd0);
    end

    assign o_stall   = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
        end
    end

endmodule
`default_nettype wire

FILE: design/aas_back.sv
// Back end: divides, builds and scales the source Jacobian, forms residuals and emits rows.
`default_nettype none
module aas_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [aas_pkg::HEAT_W-1:0]   i_heat_ratio,
    input  wire logic                         i_q_valid,
    input  wire aas_pkg::t_item               i_q_item,
    output logic                              o_q_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_row_index,
    output logic signed [31:0]                o_residual_value,
    output logic signed [31:0]                o_jacobian_entry_0,
    output logic signed [31:0]                o_jacobian_entry_1,
    output logic signed [31:0]                o_jacobian_entry_2,
    output logic signed [31:0]                o_jacobian_entry_3,
    output logic                              o_last_row,
    output logic                              o_bad_density
);
    import aas_pkg::*;

    localparam logic [4:0] STEP_UU   = 5'd0;
    localparam logic [4:0] STEP_VV   = 5'd1;
    localparam logic [4:0] STEP_UV   = 5'd2;
    localparam logic [4:0] STEP_VK   = 5'd3;
    localparam logic [4:0] STEP_VE   = 5'd4;
    localparam logic [4:0] STEP_M1   = 5'd5;
    localparam logic [4:0] STEP_M2   = 5'd6;
    localparam logic [4:0] STEP_GMUV = 5'd7;
    localparam logic [4:0] STEP_GE   = 5'd8;
    localparam logic [4:0] STEP_HALF = 5'd9;
    localparam logic [4:0] STEP_GV   = 5'd10;
    localparam logic [4:0] STEP_S02  = 5'd11;
    localparam logic [4:0] STEP_S10  = 5'd12;
    localparam logic [4:0] STEP_S11  = 5'd13;
    localparam logic [4:0] STEP_S12  = 5'd14;
    localparam logic [4:0] STEP_S20  = 5'd15;
    localparam logic [4:0] STEP_S22  = 5'd16;
    localparam logic [4:0] STEP_S30  = 5'd17;
    localparam logic [4:0] STEP_S31  = 5'd18;
    localparam logic [4:0] STEP_S32  = 5'd19;
    localparam logic [4:0] STEP_S33  = 5'd20;

    localparam logic [1:0] DQ_U = 2'd0;
    localparam logic [1:0] DQ_V = 2'd1;
    localparam logic [1:0] DQ_E = 2'd2;
    localparam logic [1:0] DQ_S = 2'd3;

    t_back_state        r_state, n_state;
    t_item              r_item;
    logic [1:0]         r_dsel;
    logic [4:0]         r_step;
    logic [3:0]         r_ridx;
    logic [1:0]         r_row;
    logic signed [31:0] r_q [NUM_VARS];
    logic signed [31:0] r_uu, r_vv, r_uv, r_vk, r_ve, r_m1, r_m2;
    logic signed [31:0] r_gmuv, r_ge, r_half, r_gv;
    logic signed [31:0] r_a [NUM_VARS][NUM_VARS];
    logic signed [31:0] r_res [NUM_VARS];
    logic signed [49:0] r_acc;

    logic               r_ovalid;
    logic [1:0]         r_orow;
    logic signed [31:0] r_ores;
    logic signed [31:0] r_oent [NUM_VARS];
    logic               r_olast;
    logic               r_obad;

    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_num;
    logic [31:0]        div_den;
    logic signed [31:0] div_quo;

    logic signed [31:0] g32, gm, uu_k, t_val, vv2;
    logic signed [31:0] mult_a, mult_b;
    logic               sh17;
    logic signed [63:0] prod, shifted;
    logic signed [31:0] mres;
    logic signed [49:0] acc_sum;
    logic               load;
    logic [1:0]         rj;
    logic [1:0]         ri;

    aas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        unique case (r_dsel)
            DQ_U: begin
                div_num = r_item.momentum_axial;
                div_den = r_item.density;
            end
            DQ_V: begin
                div_num = r_item.momentum_radial;
                div_den = r_item.density;
            end
            DQ_E: begin
                div_num = r_item.total_energy;
                div_den = r_item.density;
            end
            default: begin
                div_num = $signed({1'b0, r_item.cell_volume});
                div_den = r_item.radius;
            end
        endcase
    end

    assign g32   = $signed({14'd0, i_heat_ratio});
    assign gm    = g32 - Q_ONE;
    assign uu_k  = sat32(64'(r_uu) + 64'(r_vv));
    assign vv2   = sat32(64'(r_vv) + 64'(r_vv));
    assign t_val = sat32(64'(uu_k) + 64'(vv2));
    assign rj    = r_ridx[1:0];
    assign ri    = r_ridx[3:2];

    always_comb begin
        sh17   = 1'b0;
        mult_a = '0;
        mult_b = '0;
        if (r_state == ST_RES) begin
            mult_a = r_a[rj][ri];
            mult_b = $signed(r_item.adjoint[rj]);
        end else begin
            unique case (r_step)
                STEP_UU: begin mult_a = r_q[DQ_U]; mult_b = r_q[DQ_U]; end
                STEP_VV: begin mult_a = r_q[DQ_V]; mult_b = r_q[DQ_V]; end
                STEP_UV: begin mult_a = r_q[DQ_U]; mult_b = r_q[DQ_V]; end
                STEP_VK: begin mult_a = r_q[DQ_V]; mult_b = uu_k; end
                STEP_VE: begin mult_a = r_q[DQ_V]; mult_b = r_q[DQ_E]; end
                STEP_M1: begin mult_a = gm; mult_b = r_vk; end
                STEP_M2: begin mult_a = g32; mult_b = r_ve; end
                STEP_GMUV: begin mult_a = gm; mult_b = r_uv; end
                STEP_GE: begin mult_a = g32; mult_b = r_q[DQ_E]; end
                STEP_HALF: begin
                    // The factor one half folds into one more bit of shift.
                    mult_a = gm;
                    mult_b = t_val;
                    sh17   = 1'b1;
                end
                STEP_GV: begin mult_a = g32; mult_b = r_q[DQ_V]; end
                STEP_S02: begin mult_a = Q_ONE; mult_b = r_q[DQ_S]; end
                STEP_S10: begin mult_a = sat32(-64'(r_uv)); mult_b = r_q[DQ_S]; end
                STEP_S11: begin mult_a = r_q[DQ_V]; mult_b = r_q[DQ_S]; end
                STEP_S12: begin mult_a = r_q[DQ_U]; mult_b = r_q[DQ_S]; end
                STEP_S20: begin mult_a = sat32(-64'(r_vv)); mult_b = r_q[DQ_S]; end
                STEP_S22: begin
                    mult_a = sat32(64'(r_q[DQ_V]) + 64'(r_q[DQ_V]));
                    mult_b = r_q[DQ_S];
                end
                STEP_S30: begin
                    mult_a = sat32(64'(r_m1) - 64'(r_m2));
                    mult_b = r_q[DQ_S];
                end
                STEP_S31: begin mult_a = sat32(-64'(r_gmuv)); mult_b = r_q[DQ_S]; end
                STEP_S32: begin
                    mult_a = sat32(64'(r_ge) - 64'(r_half));
                    mult_b = r_q[DQ_S];
                end
                STEP_S33: begin mult_a = r_gv; mult_b = r_q[DQ_S]; end
                default: begin mult_a = '0; mult_b = '0; end
            endcase
        end
    end

    assign prod    = 64'(mult_a) * 64'(mult_b);
    assign shifted = sh17 ? (prod >>> 17) : (prod >>> 16);
    assign mres    = sat32(shifted);
    assign acc_sum = r_acc + shifted[49:0];
    assign load    = (r_state == ST_EMIT) && (!r_ovalid || !i_stall);

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = (i_q_item.bad || i_q_item.skip) ? ST_EMIT : ST_DSTART;
                end
            end
            ST_DSTART: begin
                div_start = 1'b1;
                n_state   = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    n_state = (r_dsel == DQ_S) ? ST_MUL : ST_DSTART;
                end
            end
            ST_MUL: begin
                if (r_step == STEP_S33) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (r_ridx == 4'd15) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load && r_row == 2'(NUM_VARS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_dsel <= DQ_U;
            r_step <= STEP_UU;
            r_ridx <= '0;
            r_row  <= '0;
            r_acc  <= '0;
            for (int i = 0; i < NUM_VARS; i++) begin
                r_res[i] <= '0;
                for (int j = 0; j < NUM_VARS; j++) begin
                    r_a[i][j] <= '0;
                end
            end
        end
        if (r_state == ST_DWAIT && div_done) begin
            r_q[r_dsel] <= div_quo;
            r_dsel      <= r_dsel + 2'd1;
        end
        if (r_state == ST_MUL) begin
            r_step <= r_step + 5'd1;
            unique case (r_step)
                STEP_UU:   r_uu   <= mres;
                STEP_VV:   r_vv   <= mres;
                STEP_UV:   r_uv   <= mres;
                STEP_VK:   r_vk   <= mres;
                STEP_VE:   r_ve   <= mres;
                STEP_M1:   r_m1   <= mres;
                STEP_M2:   r_m2   <= mres;
                STEP_GMUV: r_gmuv <= mres;
                STEP_GE:   r_ge   <= mres;
                STEP_HALF: r_half <= mres;
                STEP_GV:   r_gv   <= mres;
                STEP_S02:  r_a[0][2] <= mres;
                STEP_S10:  r_a[1][0] <= mres;
                STEP_S11:  r_a[1][1] <= mres;
                STEP_S12:  r_a[1][2] <= mres;
                STEP_S20:  r_a[2][0] <= mres;
                STEP_S22:  r_a[2][2] <= mres;
                STEP_S30:  r_a[3][0] <= mres;
                STEP_S31:  r_a[3][1] <= mres;
                STEP_S32:  r_a[3][2] <= mres;
                STEP_S33:  r_a[3][3] <= mres;
                default:   r_uu   <= r_uu;
            endcase
        end
        if (r_state == ST_RES) begin
            // Products are floored one by one, summed exactly, saturated once per row.
            r_ridx <= r_ridx + 4'd1;
            if (rj == 2'(NUM_VARS - 1)) begin
                r_res[ri] <= sat32(64'(acc_sum));
                r_acc     <= '0;
            end else begin
                r_acc <= acc_sum;
            end
        end
        if (load) begin
            r_row   <= r_row + 2'd1;
            r_orow  <= r_row;
            r_ores  <= r_res[r_row];
            r_olast <= (r_row == 2'(NUM_VARS - 1));
            r_obad  <= r_item.bad;
            for (int j = 0; j < NUM_VARS; j++) begin
                r_oent[j] <= r_a[j][r_row];
            end
        end
    end

    assign o_valid            = r_ovalid;
    assign o_row_index        = r_orow;
    assign o_residual_value   = r_ores;
    assign o_jacobian_entry_0 = r_oent[0];
    assign o_jacobian_entry_1 = r_oent[1];
    assign o_jacobian_entry_2 = r_oent[2];
    assign o_jacobian_entry_3 = r_oent[3];
    assign o_last_row         = r_olast;
    assign o_bad_density      = r_obad;

endmodule
`default_nettype wire

FILE: design/axisymmetric_adjoint_source.sv
// Top level of the axisymmetric adjoint source block: heat ratio register, front queue, back end.
// Each node word yields four rows. A node whose density or radius is zero or negative is taken
// from the queue in the back end, and its zeroed rows are then moved into the output register.
// Any other node is taken from the queue, then goes through four divisions on one shared
// bit-serial divider (u, v, e and the volume-over-radius scale), a run of steps on one shared
// multiplier to build and scale the Jacobian and the accumulation of the residuals, and then its
// rows are moved into the output register. An output stall holds the back end while it moves
// rows into the output register.
// A two-word queue lets new nodes be taken while the back end works or the output is stalled.
`default_nettype none
module axisymmetric_adjoint_source (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [aas_pkg::HEAT_W-1:0]   i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [31:0]           i_radius,
    input  wire logic [aas_pkg::VOL_W-1:0]    i_cell_volume,
    input  wire logic signed [31:0]           i_density,
    input  wire logic signed [31:0]           i_momentum_axial,
    input  wire logic signed [31:0]           i_momentum_radial,
    input  wire logic signed [31:0]           i_total_energy,
    input  wire logic signed [31:0]           i_adjoint_0,
    input  wire logic signed [31:0]           i_adjoint_1,
    input  wire logic signed [31:0]           i_adjoint_2,
    input  wire logic signed [31:0]           i_adjoint_3,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_row_index,
    output logic signed [31:0]                o_residual_value,
    output logic signed [31:0]                o_jacobian_entry_0,
    output logic signed [31:0]                o_jacobian_entry_1,
    output logic signed [31:0]                o_jacobian_entry_2,
    output logic signed [31:0]                o_jacobian_entry_3,
    output logic                              o_last_row,
    output logic                              o_bad_density
);
    import aas_pkg::*;

    logic [HEAT_W-1:0] r_heat;
    logic              q_valid;
    t_item             q_item;
    logic              q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat <= HEAT_RESET;
        end else if (i_cfg_we) begin
            r_heat <= i_cfg_data;
        end
    end

    aas_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_radius          (i_radius),
        .i_cell_volume     (i_cell_volume),
        .i_density         (i_density),
        .i_momentum_axial  (i_momentum_axial),
        .i_momentum_radial (i_momentum_radial),
        .i_total_energy    (i_total_energy),
        .i_adjoint_0       (i_adjoint_0),
        .i_adjoint_1       (i_adjoint_1),
        .i_adjoint_2       (i_adjoint_2),
        .i_adjoint_3       (i_adjoint_3),
        .o_q_valid         (q_valid),
        .o_q_item          (q_item),
        .i_q_pop           (q_pop)
    );

    aas_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_heat_ratio       (r_heat),
        .i_q_valid          (q_valid),
        .i_q_item           (q_item),
        .o_q_pop            (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_row_index        (o_row_index),
        .o_residual_value   (o_residual_value),
        .o_jacobian_entry_0 (o_jacobian_entry_0),
        .o_jacobian_entry_1 (o_jacobian_entry_1),
        .o_jacobian_entry_2 (o_jacobian_entry_2),
        .o_jacobian_entry_3 (o_jacobian_entry_3),
        .o_last_row         (o_last_row),
        .o_bad_density      (o_bad_density)
    );

endmodule
`default_nettype wire
